/* design/miller_rabin_primality_test_assert.svh */
// assertion macros used by the miller-rabin top-level design file
`ifndef MILLER_RABIN_PRIMALITY_TEST_ASSERT_SVH
`define MILLER_RABIN_PRIMALITY_TEST_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define MR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define MR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/mrpt_pkg.sv */
// package with shared types and codes of the miller-rabin tester
`default_nettype none
package mrpt_pkg;
    // verdict codes
    localparam logic [1:0] OUTCOME_PASS      = 2'd0;
    localparam logic [1:0] OUTCOME_TRIVIAL   = 2'd1;
    localparam logic [1:0] OUTCOME_COMPOSITE = 2'd2;

    // operation codes of the modular multiplier
    typedef enum logic [1:0] {
        MUL_REDUCE = 2'd0,
        MUL_PRODUCT = 2'd1
    } mul_op_t;

    // control group from sequencer to the cell row
    typedef struct packed {
        logic start;
        logic reduce_only;
    } mul_ctrl_t;
endpackage
`default_nettype wire

/* design/mrpt_if.sv */
// valid/ready channel interfaces for input and result transactions
`default_nettype none
interface mrpt_in_if #(parameter int W = 64);
    logic         valid;
    logic         ready;
    logic [W-1:0] candidate;
    logic [W-1:0] witness_base;
    logic         last_base;
    modport source (output valid, candidate, witness_base, last_base, input ready);
    modport sink (input valid, candidate, witness_base, last_base, output ready);
endinterface

interface mrpt_out_if;
    logic       valid;
    logic       ready;
    logic       probable_prime;
    logic [1:0] outcome;
    modport source (output valid, probable_prime, outcome, input ready);
    modport sink (input valid, probable_prime, outcome, output ready);
endinterface
`default_nettype wire

/* design/mrpt_cell.sv */
// one cell of the shift-and-add modular multiplier row
`default_nettype none
module mrpt_cell
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  wire logic load_bit,
    input  wire logic shift,
    input  wire logic from_neighbor,
    output logic      bit_out
);
    logic bit_reg;

    // cell holds one multiplier bit and hands it on when shift is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else if (load)
        begin
            bit_reg <= load_bit;
        end
        else if (shift)
        begin
            bit_reg <= from_neighbor;
        end
    end

    assign bit_out = bit_reg;
endmodule
`default_nettype wire

/* design/mrpt_mulmod.sv */
// modular multiplier: row of cells feeding bits into a double-and-add accumulator
`default_nettype none
module mrpt_mulmod
    import mrpt_pkg::*;
#(
    parameter int W = 64
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] x,
    input  wire logic [W-1:0] y,
    input  wire logic [W-1:0] m,
    output logic              done,
    output logic [W-1:0]      result
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  chain;
    logic [CW-1:0] count_reg, count_next;
    logic          busy_reg, busy_next;
    logic          phase_reg, phase_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg;
    logic [W-1:0]  m_reg;
    logic          done_reg, done_next;
    logic [W:0]    sum;
    logic [W:0]    diff;
    logic [W-1:0]  addend;
    logic          shift_en;

    // row of cells, msb leaves the row first
    genvar gi;
    generate
        for (gi = 0; gi < W; gi++)
        begin : g_cell
            logic nb;
            if (gi == 0)
            begin : g_lsb
                assign nb = 1'b0;
            end
            else
            begin : g_mid
                assign nb = chain[gi-1];
            end
            mrpt_cell u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .load          (start),
                .load_bit      (y[gi]),
                .shift         (shift_en),
                .from_neighbor (nb),
                .bit_out       (chain[gi])
            );
        end
    endgenerate

    assign shift_en = busy_reg && phase_reg;

    // one modular add per cycle while busy: double, then add x if bit set
    always_comb
    begin
        addend = phase_reg ? x_reg : acc_reg;
        sum    = {1'b0, acc_reg} + {1'b0, addend};
        diff   = sum - {1'b0, m_reg};
        acc_next   = acc_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            acc_next   = '0;
            phase_next = 1'b0;
            count_next = CW'(W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                acc_next   = diff[W] ? sum[W-1:0] : diff[W-1:0];
                phase_next = 1'b1;
            end
            else
            begin
                if (chain[W-1])
                begin
                    acc_next = diff[W] ? sum[W-1:0] : diff[W-1:0];
                end
                phase_next = 1'b0;
                count_next = count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            x_reg <= x;
            m_reg <= m;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;
endmodule
`default_nettype wire

/* design/miller_rabin_primality_test.sv */
// miller-rabin top level: sequencer around the cell-row modular multiplier
// at most 2*NUM_WIDTH-1 modular products per base, each on the cell-row multiplier
// one item at a time: a new item is taken only in idle, with a single shared multiplier
// trivial candidates (two, even, one) skip the multiplier and go straight to the verdict
// reset: rst_n async active low clears the latched run outcome and the sequencer
`default_nettype none
`include "miller_rabin_primality_test_assert.svh"
module miller_rabin_primality_test
    import mrpt_pkg::*;
#(
    parameter int NUM_WIDTH = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    mrpt_in_if.sink   in_ch,
    mrpt_out_if.source out_ch
);
    localparam int W  = NUM_WIDTH;
    localparam int SW = $clog2(W + 1);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_REDUCE = 9'b000000010,
        ST_SPLIT  = 9'b000000100,
        ST_POWMUL = 9'b000001000,
        ST_POWSQ  = 9'b000010000,
        ST_CHECK  = 9'b000100000,
        ST_SQ     = 9'b001000000,
        ST_VERDICT= 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [W-1:0]  n_reg, a_reg, d_reg, acc_reg, b_reg;
    logic [SW-1:0] s_reg, i_reg;
    logic          last_reg;
    logic          wait_reg;
    logic [1:0]    run_reg;
    logic          pp_reg;
    logic [1:0]    oc_reg;
    logic          mstart;
    logic [W-1:0]  mx, my;
    logic          mdone;
    logic [W-1:0]  mres;
    logic [W-1:0]  nm1;
    logic          trivial;
    logic [W-1:0]  one_w;

    assign one_w = W'(1);
    assign nm1   = n_reg - one_w;
    assign trivial = (n_reg == W'(2)) || !n_reg[0] || (n_reg == one_w);

    mrpt_mulmod #(.W(W)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mstart),
        .x      (mx),
        .y      (my),
        .m      (n_reg),
        .done   (mdone),
        .result (mres)
    );

    // operand selection and start pulse for the multiplier
    always_comb
    begin
        mx = b_reg;
        my = one_w;
        mstart = 1'b0;
        unique case (state_reg)
            ST_REDUCE: begin mx = one_w; my = a_reg; mstart = !wait_reg && !trivial; end
            ST_POWMUL: begin mx = b_reg; my = acc_reg; mstart = !wait_reg && d_reg[0]; end
            ST_POWSQ:  begin mx = b_reg; my = b_reg; mstart = !wait_reg && (d_reg != '0); end
            ST_SQ:     begin mx = acc_reg; my = acc_reg; mstart = !wait_reg; end
            default:   begin mstart = 1'b0; end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_ch.valid) state_next = ST_REDUCE;
            ST_REDUCE:
            begin
                if (trivial) state_next = ST_VERDICT;
                else if (mdone) state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                if (b_reg == '0) state_next = ST_VERDICT;
                else if (!d_reg[0]) state_next = ST_SPLIT;
                else state_next = ST_POWMUL;
            end
            ST_POWMUL: if (!d_reg[0] || mdone) state_next = ST_POWSQ;
            ST_POWSQ:
            begin
                if (d_reg == '0) state_next = ST_CHECK;
                else if (mdone) state_next = ST_POWMUL;
            end
            ST_CHECK:  state_next = ST_VERDICT;
            ST_SQ:     if (mdone) state_next = ST_CHECK;
            ST_VERDICT: state_next = last_reg ? ST_OUT : ST_IDLE;
            ST_OUT:    if (out_ch.ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
        if (state_reg == ST_CHECK)
        begin
            if ((i_reg == '0) && ((acc_reg == one_w) || (acc_reg == nm1)))
                state_next = ST_VERDICT;
            else if ((i_reg != '0) && (acc_reg == nm1))
                state_next = ST_VERDICT;
            else if (i_reg + 1'b1 < s_reg)
                state_next = ST_SQ;
            else
                state_next = ST_VERDICT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wait_reg  <= 1'b0;
            run_reg   <= OUTCOME_PASS;
        end
        else
        begin
            state_reg <= state_next;
            // wait flag: multiplier running for this state
            if (mstart) wait_reg <= 1'b1;
            else if (mdone || state_next != state_reg) wait_reg <= 1'b0;
            if (state_reg == ST_CHECK && state_next == ST_VERDICT)
            begin
                if (!((i_reg == '0) && ((acc_reg == one_w) || (acc_reg == nm1)))
                    && !((i_reg != '0) && (acc_reg == nm1)))
                    run_reg <= OUTCOME_COMPOSITE;
            end
            if (state_reg == ST_VERDICT && last_reg)
                run_reg <= OUTCOME_PASS;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                n_reg    <= in_ch.candidate;
                a_reg    <= in_ch.witness_base;
                last_reg <= in_ch.last_base;
                d_reg    <= in_ch.candidate - one_w;
                s_reg    <= '0;
                i_reg    <= '0;
            end
            ST_REDUCE:
            begin
                if (mdone) b_reg <= mres;
                acc_reg <= one_w;
            end
            ST_SPLIT:
            begin
                if (!d_reg[0])
                begin
                    d_reg <= d_reg >> 1;
                    s_reg <= s_reg + 1'b1;
                end
            end
            ST_POWMUL:
            begin
                if (mdone) acc_reg <= mres;
            end
            ST_POWSQ:
            begin
                if (state_next != ST_POWSQ && d_reg != '0)
                begin
                    if (mdone) b_reg <= mres;
                    d_reg <= d_reg >> 1;
                end
                else if (mdone)
                    b_reg <= mres;
            end
            ST_CHECK:
            begin
                if (state_next == ST_SQ && !((i_reg == '0) && (acc_reg != nm1) && 1'b0))
                    i_reg <= i_reg + 1'b1;
            end
            ST_SQ:
            begin
                if (mdone) acc_reg <= mres;
            end
            ST_VERDICT:
            begin
                if (n_reg == W'(2))
                begin
                    pp_reg <= 1'b1; oc_reg <= OUTCOME_PASS;
                end
                else if (!n_reg[0] || n_reg == one_w)
                begin
                    pp_reg <= 1'b0; oc_reg <= OUTCOME_TRIVIAL;
                end
                else
                begin
                    // include a failure found on this very base
                    pp_reg <= (run_reg == OUTCOME_PASS);
                    oc_reg <= run_reg;
                end
            end
            default: ;
        endcase
    end

    assign in_ch.ready           = (state_reg == ST_IDLE);
    assign out_ch.valid          = (state_reg == ST_OUT);
    assign out_ch.probable_prime = pp_reg;
    assign out_ch.outcome        = oc_reg;

    `MR_ASSERT_IMP(a_out_one_hot, clk, rst_n, out_ch.valid, !in_ch.ready)
    `MR_ASSERT_IMP(a_pp_code, clk, rst_n, out_ch.valid, out_ch.probable_prime == (out_ch.outcome == OUTCOME_PASS))
    `MR_ASSERT_NXT(a_run_clear, clk, rst_n, state_reg == ST_VERDICT && last_reg, run_reg == OUTCOME_PASS)
endmodule
`default_nettype wire
